// ===== hw/rtl/stsch_pkg.sv =====
// Package for the slot timer scheduler: command codes, internal operation codes,
// widths and the command record passed from the front end to the back end.
// No dependencies.
`default_nettype none

package stsch_pkg;

    localparam int TIME_W         = 64;
    localparam int SLOT_COUNT_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int GEN_W          = 16;
    localparam int HANDLE_W       = 32;

    // Command codes on the input channel.
    localparam logic [2:0] CMD_ARM_ONCE = 3'd0;
    localparam logic [2:0] CMD_ARM_PER  = 3'd1;
    localparam logic [2:0] CMD_CANCEL   = 3'd2;
    localparam logic [2:0] CMD_QUERY    = 3'd3;
    localparam logic [2:0] CMD_EXPIRE   = 3'd4;

    // Operations after classification by the front end.
    localparam logic [2:0] OP_ARM_ONCE = 3'd0;
    localparam logic [2:0] OP_ARM_PER  = 3'd1;
    localparam logic [2:0] OP_CANCEL   = 3'd2;
    localparam logic [2:0] OP_QUERY    = 3'd3;
    localparam logic [2:0] OP_EXPIRE   = 3'd4;
    localparam logic [2:0] OP_NOP      = 3'd5;

    typedef struct packed {
        logic [2:0]          op;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   interval;
        logic [7:0]          source;
        logic [15:0]         code;
        logic [31:0]         arg0;
        logic [31:0]         arg1;
        logic [HANDLE_W-1:0] handle;
    } stsch_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stsch_front.sv =====
// Front end of the slot timer scheduler: accepts command transactions, classifies
// them and holds them in a short queue for the back end. Depends on stsch_pkg.
`default_nettype none

module stsch_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          command,
    input  wire logic [63:0]         now_us,
    input  wire logic [63:0]         interval_us,
    input  wire logic [7:0]          event_source,
    input  wire logic [15:0]         event_code,
    input  wire logic [31:0]         event_arg0,
    input  wire logic [31:0]         event_arg1,
    input  wire logic [31:0]         handle,
    output logic                     q_valid,
    input  wire logic                q_ready,
    output stsch_pkg::stsch_cmd_t    q_cmd
);
    import stsch_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    stsch_cmd_t           entry_reg [QUEUE_DEPTH];
    logic [QAW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0]       count_reg;
    stsch_cmd_t           cls;
    logic                 push, pop;

    // Classification: arm-once with zero delay becomes one, a zero period is rejected.
    always_comb
    begin
        cls.now      = now_us;
        cls.interval = interval_us;
        cls.source   = event_source;
        cls.code     = event_code;
        cls.arg0     = event_arg0;
        cls.arg1     = event_arg1;
        cls.handle   = handle;
        unique case (command)
            CMD_ARM_ONCE:
            begin
                cls.op = OP_ARM_ONCE;
                if (interval_us == '0)
                    cls.interval = TIME_W'(1);
            end
            CMD_ARM_PER: cls.op = (interval_us == '0) ? OP_NOP : OP_ARM_PER;
            CMD_CANCEL:  cls.op = OP_CANCEL;
            CMD_QUERY:   cls.op = OP_QUERY;
            CMD_EXPIRE:  cls.op = OP_EXPIRE;
            default:     cls.op = OP_NOP;
        endcase
    end

    assign in_ready = (count_reg != QCW'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stsch_back.sv =====
// Back end of the slot timer scheduler: slot table, sequencer, bit-serial
// catch-up remainder unit, earliest-due scan and output register. Depends on stsch_pkg.
`default_nettype none

module stsch_back #(
    parameter int SLOT_COUNT = stsch_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire stsch_pkg::stsch_cmd_t q_cmd,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     kind,
    output logic                     success,
    output logic [31:0]              new_handle,
    output logic [7:0]               fired_source,
    output logic [15:0]              fired_code,
    output logic [31:0]              fired_arg0,
    output logic [31:0]              fired_arg1,
    output logic                     last,
    output logic                     timer_armed,
    output logic [63:0]              timer_due_us,
    output logic [63:0]              timer_start_delay_us
);
    import stsch_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ARM      = 4'd1;
    localparam logic [3:0] S_LOOK     = 4'd2;
    localparam logic [3:0] S_EXP_RD   = 4'd3;
    localparam logic [3:0] S_EXP_FIRE = 4'd4;
    localparam logic [3:0] S_EXP_UPD  = 4'd5;
    localparam logic [3:0] S_DIV      = 4'd6;
    localparam logic [3:0] S_SCAN     = 4'd7;
    localparam logic [3:0] S_DECIDE   = 4'd8;
    localparam logic [3:0] S_REPLY    = 4'd9;

    // Slot table.
    logic                slot_active_reg [SLOT_COUNT];
    logic [GEN_W-1:0]    slot_gen_reg    [SLOT_COUNT];
    logic [TIME_W-1:0]   slot_due_reg    [SLOT_COUNT];
    logic [TIME_W-1:0]   slot_period_reg [SLOT_COUNT];
    logic [7:0]          slot_source_reg [SLOT_COUNT];
    logic [15:0]         slot_code_reg   [SLOT_COUNT];
    logic [31:0]         slot_arg0_reg   [SLOT_COUNT];
    logic [31:0]         slot_arg1_reg   [SLOT_COUNT];

    logic [3:0]          state_reg, state_next;
    stsch_cmd_t          cmd_reg;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                armed_reg, armed_next;
    logic [TIME_W-1:0]   due_reg, due_next;
    logic                ok_reg, ok_next;
    logic [HANDLE_W-1:0] tok_reg, tok_next;
    logic [TIME_W-1:0]   delay_reg, delay_next;
    logic                found_reg, found_next;
    logic [TIME_W-1:0]   best_reg, best_next;
    logic [TIME_W-1:0]   nxt_reg, nxt_next;
    logic [TIME_W:0]     rem_reg, rem_next;
    logic [TIME_W-1:0]   dvd_reg, dvd_next;
    logic [6:0]          cnt_reg, cnt_next;

    logic                ov_reg;
    logic                o_kind_reg, o_succ_reg, o_last_reg, o_armed_reg;
    logic [31:0]         o_handle_reg, o_arg0_reg, o_arg1_reg;
    logic [7:0]          o_src_reg;
    logic [15:0]         o_code_reg;
    logic [63:0]         o_due_reg, o_delay_reg;

    logic                out_free, load_fire, load_reply;
    logic [IW-1:0]       free_idx, look_idx, rd_idx, wr_idx;
    logic                any_free, look_hit;
    logic [15:0]         look_lo;
    logic [GEN_W-1:0]    gen_new;
    logic [TIME_W:0]     rem_sh;

    // Table write controls.
    logic                wr_slot, clr_active, wr_due;
    logic [TIME_W-1:0]   wr_due_val;

    assign out_free = !ov_reg || out_ready;

    // Lowest free slot.
    always_comb
    begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!slot_active_reg[i])
            begin
                free_idx = IW'(i);
                any_free = 1'b1;
            end
        end
    end

    assign look_lo  = cmd_reg.handle[15:0];
    assign look_idx = IW'(look_lo - 16'd1);
    assign rd_idx   = (state_reg == S_LOOK) ? look_idx : idx_reg[IW-1:0];
    assign wr_idx   = (state_reg == S_ARM) ? free_idx : rd_idx;
    assign look_hit = (look_lo != 16'd0) && (look_lo <= 16'(SLOT_COUNT))
                      && slot_active_reg[rd_idx]
                      && (slot_gen_reg[rd_idx] == cmd_reg.handle[31:16]);
    assign gen_new  = (slot_gen_reg[free_idx] == {GEN_W{1'b1}}) ? GEN_W'(1)
                      : slot_gen_reg[free_idx] + 1'b1;
    assign rem_sh   = {rem_reg[TIME_W-1:0], dvd_reg[TIME_W-1]};

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        armed_next = armed_reg;
        due_next   = due_reg;
        ok_next    = ok_reg;
        tok_next   = tok_reg;
        delay_next = delay_reg;
        found_next = found_reg;
        best_next  = best_reg;
        nxt_next   = nxt_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        cnt_next   = cnt_reg;
        q_ready    = 1'b0;
        load_fire  = 1'b0;
        load_reply = 1'b0;
        wr_slot    = 1'b0;
        clr_active = 1'b0;
        wr_due     = 1'b0;
        wr_due_val = nxt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                q_ready    = 1'b1;
                ok_next    = 1'b0;
                tok_next   = '0;
                delay_next = '0;
                idx_next   = '0;
                found_next = 1'b0;
                if (q_valid)
                begin
                    unique case (q_cmd.op)
                        OP_ARM_ONCE, OP_ARM_PER: state_next = S_ARM;
                        OP_CANCEL, OP_QUERY:     state_next = S_LOOK;
                        OP_EXPIRE:
                        begin
                            armed_next = 1'b0;
                            due_next   = '0;
                            state_next = S_EXP_RD;
                        end
                        default:                 state_next = S_REPLY;
                    endcase
                end
            end
            S_ARM:
            begin
                if (any_free)
                begin
                    wr_slot    = 1'b1;
                    ok_next    = 1'b1;
                    tok_next   = {gen_new, 16'(free_idx) + 16'd1};
                    state_next = S_SCAN;
                end
                else
                    state_next = S_REPLY;
            end
            S_LOOK:
            begin
                if (look_hit)
                begin
                    ok_next = 1'b1;
                    if (cmd_reg.op == OP_CANCEL)
                    begin
                        clr_active = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                        state_next = S_REPLY;
                end
                else
                    state_next = S_REPLY;
            end
            S_EXP_RD:
            begin
                if (idx_reg == CW'(SLOT_COUNT))
                begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
                else if (slot_active_reg[rd_idx] && slot_due_reg[rd_idx] <= cmd_reg.now)
                    state_next = S_EXP_FIRE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_EXP_FIRE:
            begin
                if (out_free)
                begin
                    load_fire = 1'b1;
                    if (slot_period_reg[rd_idx] == '0)
                    begin
                        clr_active = 1'b1;
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_EXP_RD;
                    end
                    else
                    begin
                        nxt_next   = slot_due_reg[rd_idx] + slot_period_reg[rd_idx];
                        state_next = S_EXP_UPD;
                    end
                end
            end
            S_EXP_UPD:
            begin
                if (nxt_reg <= cmd_reg.now)
                begin
                    rem_next   = '0;
                    dvd_next   = cmd_reg.now - nxt_reg;
                    cnt_next   = 7'(TIME_W);
                    state_next = S_DIV;
                end
                else
                begin
                    wr_due     = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_EXP_RD;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    // next + (q+1)*period equals now - remainder + period.
                    wr_due     = 1'b1;
                    wr_due_val = cmd_reg.now - rem_reg[TIME_W-1:0]
                                 + slot_period_reg[rd_idx];
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_EXP_RD;
                end
                else
                begin
                    if (rem_sh >= {1'b0, slot_period_reg[rd_idx]})
                        rem_next = rem_sh - {1'b0, slot_period_reg[rd_idx]};
                    else
                        rem_next = rem_sh;
                    dvd_next = {dvd_reg[TIME_W-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == CW'(SLOT_COUNT))
                    state_next = S_DECIDE;
                else
                begin
                    if (slot_active_reg[rd_idx]
                        && (!found_reg || slot_due_reg[rd_idx] < best_reg))
                    begin
                        found_next = 1'b1;
                        best_next  = slot_due_reg[rd_idx];
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                state_next = S_REPLY;
                if (!found_reg)
                begin
                    armed_next = 1'b0;
                    due_next   = '0;
                    delay_next = '0;
                end
                else if (armed_reg && best_reg == due_reg)
                    delay_next = '0;
                else
                begin
                    delay_next = (best_reg > cmd_reg.now) ? best_reg - cmd_reg.now
                                 : TIME_W'(1);
                    armed_next = 1'b1;
                    due_next   = best_reg;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    load_reply = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            armed_reg <= 1'b0;
            due_reg   <= '0;
            ok_reg    <= 1'b0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_active_reg[i] <= 1'b0;
                slot_gen_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            armed_reg <= armed_next;
            due_reg   <= due_next;
            ok_reg    <= ok_next;
            found_reg <= found_next;
            cnt_reg   <= cnt_next;
            if (load_fire || load_reply)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            if (wr_slot)
            begin
                slot_active_reg[wr_idx] <= 1'b1;
                slot_gen_reg[wr_idx]    <= gen_new;
            end
            else if (clr_active)
                slot_active_reg[wr_idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
            cmd_reg <= q_cmd;
        tok_reg   <= tok_next;
        delay_reg <= delay_next;
        best_reg  <= best_next;
        nxt_reg   <= nxt_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        if (wr_slot)
        begin
            slot_due_reg[wr_idx]    <= cmd_reg.now + cmd_reg.interval;
            slot_period_reg[wr_idx] <= (cmd_reg.op == OP_ARM_PER) ? cmd_reg.interval : '0;
            slot_source_reg[wr_idx] <= cmd_reg.source;
            slot_code_reg[wr_idx]   <= cmd_reg.code;
            slot_arg0_reg[wr_idx]   <= cmd_reg.arg0;
            slot_arg1_reg[wr_idx]   <= cmd_reg.arg1;
        end
        else if (wr_due)
            slot_due_reg[wr_idx] <= wr_due_val;
        if (load_fire)
        begin
            o_kind_reg   <= 1'b1;
            o_succ_reg   <= 1'b0;
            o_handle_reg <= '0;
            o_src_reg    <= slot_source_reg[rd_idx];
            o_code_reg   <= slot_code_reg[rd_idx];
            o_arg0_reg   <= slot_arg0_reg[rd_idx];
            o_arg1_reg   <= slot_arg1_reg[rd_idx];
            o_last_reg   <= 1'b0;
            o_armed_reg  <= 1'b0;
            o_due_reg    <= '0;
            o_delay_reg  <= '0;
        end
        else if (load_reply)
        begin
            o_kind_reg   <= 1'b0;
            o_succ_reg   <= ok_reg;
            o_handle_reg <= ok_reg ? tok_reg : '0;
            o_src_reg    <= '0;
            o_code_reg   <= '0;
            o_arg0_reg   <= '0;
            o_arg1_reg   <= '0;
            o_last_reg   <= 1'b1;
            o_armed_reg  <= armed_reg;
            o_due_reg    <= due_reg;
            o_delay_reg  <= delay_reg;
        end
    end

    assign out_valid            = ov_reg;
    assign kind                 = o_kind_reg;
    assign success              = o_succ_reg;
    assign new_handle           = o_handle_reg;
    assign fired_source         = o_src_reg;
    assign fired_code           = o_code_reg;
    assign fired_arg0           = o_arg0_reg;
    assign fired_arg1           = o_arg1_reg;
    assign last                 = o_last_reg;
    assign timer_armed          = o_armed_reg;
    assign timer_due_us         = o_due_reg;
    assign timer_start_delay_us = o_delay_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/slot_timer_scheduler.sv =====
// Top level of the slot timer scheduler: front end with command queue and back
// end with slot table and sequencer. Depends on stsch_pkg, stsch_front, stsch_back.
//
// Usage: software-paced commands enter on the in_valid/in_ready channel, one
// transaction per command (arm once, arm periodic, cancel, query, expire).
// Each command produces zero or more fired-event transactions (expire only,
// in slot order) followed by exactly one reply transaction with last set,
// carrying the one-shot timer state on the out_valid/out_ready channel.
// A two-entry queue decouples acceptance from execution, so new commands are
// taken while the back end works or while a result waits for the receiver.
// Commands are executed one at a time. A successful arm or cancel and every
// expire end with the earliest-due scan over all slots; expire first visits
// every slot, fires the due ones and, for each periodic slot whose next due
// time is still not after now, runs the bit-serial remainder unit, which
// handles one bit per cycle. The earliest-due scan visits one slot per cycle.
// When the receiver stalls, the sequencer holds at the next result and the
// queue fills, after which in_ready drops.
// Reset empties the queue, frees all slots, clears generations and disarms
// the one-shot timer; no clearing pass is needed.
`default_nettype none

module slot_timer_scheduler #(
    parameter int SLOT_COUNT = stsch_pkg::SLOT_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  command,
    input  wire logic [63:0] now_us,
    input  wire logic [63:0] interval_us,
    input  wire logic [7:0]  event_source,
    input  wire logic [15:0] event_code,
    input  wire logic [31:0] event_arg0,
    input  wire logic [31:0] event_arg1,
    input  wire logic [31:0] handle,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic             success,
    output logic [31:0]      new_handle,
    output logic [7:0]       fired_source,
    output logic [15:0]      fired_code,
    output logic [31:0]      fired_arg0,
    output logic [31:0]      fired_arg1,
    output logic             last,
    output logic             timer_armed,
    output logic [63:0]      timer_due_us,
    output logic [63:0]      timer_start_delay_us
);
    import stsch_pkg::*;

    logic       q_valid, q_ready;
    stsch_cmd_t q_cmd;

    // Front end: classification and command queue.
    stsch_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .now_us       (now_us),
        .interval_us  (interval_us),
        .event_source (event_source),
        .event_code   (event_code),
        .event_arg0   (event_arg0),
        .event_arg1   (event_arg1),
        .handle       (handle),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cmd        (q_cmd)
    );

    // Back end: slot table, scans, catch-up and result register.
    stsch_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .q_valid              (q_valid),
        .q_ready              (q_ready),
        .q_cmd                (q_cmd),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .kind                 (kind),
        .success              (success),
        .new_handle           (new_handle),
        .fired_source         (fired_source),
        .fired_code           (fired_code),
        .fired_arg0           (fired_arg0),
        .fired_arg1           (fired_arg1),
        .last                 (last),
        .timer_armed          (timer_armed),
        .timer_due_us         (timer_due_us),
        .timer_start_delay_us (timer_start_delay_us)
    );

`ifndef SYNTHESIS
    // A disarmed timer always reports a zero due time.
    a_disarmed_due_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kind && !timer_armed) |-> (timer_due_us == 64'd0))
        else $error("reply shows a due time while the timer is disarmed");

    // A restart delay is only reported when the timer ends up armed.
    a_delay_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && timer_start_delay_us != 64'd0) |-> (timer_armed && !kind))
        else $error("restart delay without an armed timer");

    // Fired events never close a command and never report success.
    a_fired_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind) |-> (!last && !success && new_handle == 32'd0))
        else $error("fired event carries reply fields");
`endif

endmodule

`default_nettype wire

// ===== dv/stsch_checker.sv =====
// Checker for the slot timer scheduler: watches both channels, keeps its own slot table
// and one-shot state, predicts the results of every command and compares them.
// Depends on stsch_pkg.
`timescale 1ns / 1ps

module stsch_checker #(
    parameter int SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [2:0]  command,
    input  wire logic [63:0] now_us,
    input  wire logic [63:0] interval_us,
    input  wire logic [7:0]  event_source,
    input  wire logic [15:0] event_code,
    input  wire logic [31:0] event_arg0,
    input  wire logic [31:0] event_arg1,
    input  wire logic [31:0] handle,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic        kind,
    input  wire logic        success,
    input  wire logic [31:0] new_handle,
    input  wire logic [7:0]  fired_source,
    input  wire logic [15:0] fired_code,
    input  wire logic [31:0] fired_arg0,
    input  wire logic [31:0] fired_arg1,
    input  wire logic        last,
    input  wire logic        timer_armed,
    input  wire logic [63:0] timer_due_us,
    input  wire logic [63:0] timer_start_delay_us,
    output int               fail_count,
    output int               pending_count
);
    import stsch_pkg::*;

    typedef struct packed {
        logic        kind;
        logic        success;
        logic [31:0] new_handle;
        logic [7:0]  source;
        logic [15:0] code;
        logic [31:0] arg0;
        logic [31:0] arg1;
        logic        last;
        logic        armed;
        logic [63:0] due;
        logic [63:0] delay;
    } sched_result_t;

    sched_result_t result_fifo[$];

    logic        busy_q[SLOTS];
    logic [15:0] gen_q[SLOTS];
    logic [63:0] due_q[SLOTS];
    logic [63:0] period_q[SLOTS];
    logic [7:0]  src_q[SLOTS];
    logic [15:0] code_q[SLOTS];
    logic [31:0] a0_q[SLOTS];
    logic [31:0] a1_q[SLOTS];
    logic        shot_armed;
    logic [63:0] shot_due;

    // Point the one-shot at the earliest due slot and return the delay that was started.
    function automatic logic [63:0] retarget(logic [63:0] t_now);
        logic        found;
        logic [63:0] best;
        found = 1'b0;
        best  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (busy_q[i] && (!found || due_q[i] < best)) begin
                best  = due_q[i];
                found = 1'b1;
            end
        end
        if (!found) begin
            shot_armed = 1'b0;
            shot_due   = '0;
            return '0;
        end
        if (shot_armed && best == shot_due) begin
            return '0;
        end
        shot_armed = 1'b1;
        shot_due   = best;
        return (best > t_now) ? best - t_now : 64'd1;
    endfunction

    // Returns the slot a token names, or -1 when the token is stale or malformed.
    function automatic int find_slot(logic [31:0] tok);
        int idx;
        if (tok[15:0] == 16'd0 || tok[15:0] > SLOTS) begin
            return -1;
        end
        idx = int'(tok[15:0]) - 1;
        if (!busy_q[idx] || gen_q[idx] != tok[31:16]) begin
            return -1;
        end
        return idx;
    endfunction

    task automatic predict_command();
        sched_result_t r;
        logic [63:0]   ivl;
        logic [63:0]   next;
        logic [63:0]   steps;
        logic [63:0]   delay;
        logic [31:0]   tok;
        logic [15:0]   g;
        logic          ok;
        int            idx;
        delay = '0;
        tok   = '0;
        ok    = 1'b0;
        ivl   = interval_us;
        if (command == CMD_ARM_ONCE || (command == CMD_ARM_PER && ivl != 0)) begin
            if (command == CMD_ARM_ONCE && ivl == 0) begin
                ivl = 64'd1;
            end
            idx = -1;
            for (int i = SLOTS - 1; i >= 0; i--) begin
                if (!busy_q[i]) begin
                    idx = i;
                end
            end
            if (idx >= 0) begin
                g = gen_q[idx] + 16'd1;
                if (g == 16'd0) begin
                    g = 16'd1;
                end
                busy_q[idx]   = 1'b1;
                gen_q[idx]    = g;
                due_q[idx]    = now_us + ivl;
                period_q[idx] = (command == CMD_ARM_PER) ? ivl : 64'd0;
                src_q[idx]    = event_source;
                code_q[idx]   = event_code;
                a0_q[idx]     = event_arg0;
                a1_q[idx]     = event_arg1;
                delay         = retarget(now_us);
                tok           = {g, 16'(idx + 1)};
                ok            = 1'b1;
            end
        end else if (command == CMD_CANCEL) begin
            idx = find_slot(handle);
            if (idx >= 0) begin
                busy_q[idx] = 1'b0;
                delay       = retarget(now_us);
                ok          = 1'b1;
            end
        end else if (command == CMD_QUERY) begin
            ok = find_slot(handle) >= 0;
        end else if (command == CMD_EXPIRE) begin
            shot_armed = 1'b0;
            shot_due   = '0;
            for (int i = 0; i < SLOTS; i++) begin
                if (busy_q[i] && due_q[i] <= now_us) begin
                    r        = '0;
                    r.kind   = 1'b1;
                    r.source = src_q[i];
                    r.code   = code_q[i];
                    r.arg0   = a0_q[i];
                    r.arg1   = a1_q[i];
                    result_fifo.push_back(r);
                    if (period_q[i] == 0) begin
                        busy_q[i] = 1'b0;
                    end else begin
                        // Catch up past now in one step rather than firing every missed period.
                        next = due_q[i] + period_q[i];
                        if (next <= now_us) begin
                            steps = (now_us - next) / period_q[i] + 64'd1;
                            next  = next + steps * period_q[i];
                        end
                        due_q[i] = next;
                    end
                end
            end
            delay = retarget(now_us);
        end
        r            = '0;
        r.success    = ok;
        r.new_handle = ok ? tok : 32'd0;
        r.last       = 1'b1;
        r.armed      = shot_armed;
        r.due        = shot_due;
        r.delay      = delay;
        result_fifo.push_back(r);
    endtask

    task automatic check_result();
        sched_result_t want;
        sched_result_t got;
        got = '{kind, success, new_handle, fired_source, fired_code, fired_arg0,
                fired_arg1, last, timer_armed, timer_due_us, timer_start_delay_us};
        if (result_fifo.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("[%0t] unexpected result %h", $realtime, got);
            end
            return;
        end
        want = result_fifo.pop_front();
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("[%0t] mismatch: kind %0d/%0d success %0d/%0d handle %h/%h",
                         $realtime, want.kind, got.kind, want.success, got.success,
                         want.new_handle, got.new_handle);
                $display("    payload exp %h %h %h %h act %h %h %h %h", want.source,
                         want.code, want.arg0, want.arg1, got.source, got.code,
                         got.arg0, got.arg1);
                $display("    last %0d/%0d armed %0d/%0d due %h/%h delay %h/%h",
                         want.last, got.last, want.armed, got.armed, want.due, got.due,
                         want.delay, got.delay);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                busy_q[i]   = 1'b0;
                gen_q[i]    = '0;
                due_q[i]    = '0;
                period_q[i] = '0;
                src_q[i]    = '0;
                code_q[i]   = '0;
                a0_q[i]     = '0;
                a1_q[i]     = '0;
            end
            shot_armed = 1'b0;
            shot_due   = '0;
            result_fifo.delete();
            fail_count = 0;
        end else begin
            if (out_valid && out_ready) begin
                check_result();
            end
            if (in_valid && in_ready) begin
                predict_command();
            end
        end
        pending_count = result_fifo.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// Top of the slot timer scheduler testbench: clock, reset, command stimulus with random
// gaps, a stalling receiver and the verdict. Depends on stsch_pkg, stsch_checker and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import stsch_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [63:0] now_us;
    logic [63:0] interval_us;
    logic [7:0]  event_source;
    logic [15:0] event_code;
    logic [31:0] event_arg0;
    logic [31:0] event_arg1;
    logic [31:0] handle;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic        success;
    logic [31:0] new_handle;
    logic [7:0]  fired_source;
    logic [15:0] fired_code;
    logic [31:0] fired_arg0;
    logic [31:0] fired_arg1;
    logic        last;
    logic        timer_armed;
    logic [63:0] timer_due_us;
    logic [63:0] timer_start_delay_us;
    int          fail_count;
    int          pending_count;

    // Set by the stimulus process to make the receiver hold off for a long stretch.
    bit          hold_off_req;
    bit          stim_done;

    // Model of the software clock: time only moves forward in the stimulus,
    // apart from the wrap cases that are forced on purpose.
    logic [63:0] clock_us;
    // Plausible tokens recorded so far, replayed later for cancel and query.
    logic [31:0] token_log[$];

    slot_timer_scheduler dut (.*);

    stsch_checker u_checker (.*);

    initial begin
        clk = 1'b0;
        forever begin
            #2 clk = ~clk;
        end
    end

    // Watchdog: fails the test if the run does not finish in time.
    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Gap length: usually none or short, now and then a long pause.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            return 0;
        end else if (roll < 93) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 120);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request so that the queue fills.
    initial begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                out_ready = 1'b0;
                repeat (600) @(negedge clk);
                hold_off_req = 1'b0;
                out_ready = 1'b1;
            end else if (stim_done || $urandom_range(0, 3) != 0) begin
                out_ready = 1'b1;
            end else begin
                out_ready = 1'b0;
                stall = pick_gap();
                repeat (stall) @(negedge clk);
                out_ready = 1'b1;
            end
        end
    end

    // Offers one command and holds it until it is taken. Arm replies are not
    // visible here, so the caller records plausible tokens with random
    // generations instead.
    task automatic send_command(logic [2:0] cmd, logic [63:0] t_now, logic [63:0] ivl,
                                logic [31:0] tok);
        int gap;
        gap = pick_gap();
        repeat (gap) @(negedge clk);
        command      = cmd;
        now_us       = t_now;
        interval_us  = ivl;
        event_source = 8'($urandom);
        event_code   = 16'($urandom);
        event_arg0   = $urandom;
        event_arg1   = $urandom;
        handle       = tok;
        in_valid     = 1'b1;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_count != 0) begin
            @(negedge clk);
        end
    endtask

    // Token guess: usually a logged token, else a random slot with a small generation or random bits.
    function automatic logic [31:0] pick_token();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6 && token_log.size() != 0) begin
            return token_log[$urandom_range(0, token_log.size() - 1)];
        end else if (roll < 8) begin
            return {16'($urandom_range(1, 40)), 16'($urandom_range(1, 16))};
        end
        return $urandom;
    endfunction

    task automatic random_command();
        int          roll;
        logic [63:0] ivl;
        logic [2:0]  cmd;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) begin
            ivl = {$urandom, $urandom};
        end else begin
            ivl = 64'($urandom_range(0, 300));
        end
        if (roll < 30) begin
            cmd = CMD_ARM_ONCE;
        end else if (roll < 50) begin
            cmd = CMD_ARM_PER;
        end else if (roll < 62) begin
            cmd = CMD_CANCEL;
        end else if (roll < 72) begin
            cmd = CMD_QUERY;
        end else if (roll < 97) begin
            cmd = CMD_EXPIRE;
            // Steps past one period exercise the catch-up division.
            clock_us = clock_us + 64'($urandom_range(0, 900));
        end else begin
            cmd = 3'($urandom_range(5, 7));
        end
        // Record one plausible token: a random generation and a random slot.
        token_log.push_back({16'($urandom_range(1, 30)), 16'($urandom_range(1, 16))});
        send_command(cmd, clock_us, ivl, pick_token());
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_QUERY;
        now_us       = '0;
        interval_us  = '0;
        event_source = '0;
        event_code   = '0;
        event_arg0   = '0;
        event_arg1   = '0;
        handle       = '0;
        hold_off_req = 1'b0;
        stim_done    = 1'b0;
        clock_us     = 64'd1000;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: query on an empty table, zero delays, zero period,
        // bad tokens, unknown codes, wrap of the time sums, and a full table.
        send_command(CMD_QUERY, 64'd0, 64'd0, 32'h0000_0000);
        send_command(CMD_ARM_ONCE, 64'd100, 64'd0, 32'd0);
        send_command(CMD_ARM_PER, 64'd100, 64'd0, 32'd0);
        send_command(CMD_QUERY, 64'd100, 64'd0, 32'h0001_0001);
        send_command(CMD_QUERY, 64'd100, 64'd0, 32'h0002_0001);
        send_command(CMD_CANCEL, 64'd100, 64'd0, 32'h0001_0011);
        send_command(CMD_CANCEL, 64'd100, 64'd0, 32'hFFFF_FFFF);
        send_command(CMD_ARM_PER, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, 32'd0);
        send_command(CMD_ARM_ONCE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     32'd0);
        send_command(CMD_EXPIRE, 64'd50, 64'd0, 32'd0);
        send_command(CMD_EXPIRE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'd0);
        send_command(3'd5, 64'd0, 64'd0, 32'd0);
        send_command(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 17; i++) begin
            send_command(CMD_ARM_PER, 64'd200, 64'(3 + i), 32'd0);
        end
        send_command(CMD_EXPIRE, 64'd100_000, 64'd0, 32'd0);
        send_command(CMD_CANCEL, 64'd100_000, 64'd0, 32'h0001_0002);
        send_command(CMD_QUERY, 64'd100_000, 64'd0, 32'h0001_0003);
        send_command(CMD_EXPIRE, 64'd200_000, 64'd0, 32'd0);
        wait_drained();
        clock_us = 64'd300_000;

        for (int n = 0; n < 300; n++) begin
            if (n == 100) begin
                // Long receiver stall while commands keep coming in.
                hold_off_req = 1'b1;
            end
            if (n == 200) begin
                wait_drained();
            end
            random_command();
        end
        stim_done = 1'b1;
        wait_drained();
        repeat (200) @(negedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
